// ----- hw/rtl/cubic_ext_field_alu_top_macros.svh -----
// ----------------------------------------------------------------------------
// cubic_ext_field_alu_top_macros
// Assertion macros for the checker of the extension field ALU.
// ----------------------------------------------------------------------------
`ifndef CUBIC_EXT_FIELD_ALU_TOP_MACROS_SVH
`define CUBIC_EXT_FIELD_ALU_TOP_MACROS_SVH

// same-cycle implication
`define CEFA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CEFA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/cefa_pkg.sv -----
// ----------------------------------------------------------------------------
// cefa_pkg
// Types, codes and base-field helpers for the cubic extension field ALU
// over GF(p)[x]/(x^3 - x + 1), p = 2^64 - 2^32 + 1.
// ----------------------------------------------------------------------------
`default_nettype none
package cefa_pkg;

	localparam logic [63:0] FIELD_P = 64'hFFFF_FFFF_0000_0001;

	typedef enum logic [2:0] {
		CMD_ADD = 3'd0,
		CMD_SUB = 3'd1,
		CMD_MUL = 3'd2,
		CMD_NEG = 3'd3,
		CMD_POW = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_RED1,
		ST_RED2,
		ST_RED3,
		ST_ACC,
		ST_PSTEP,
		ST_FIN
	} st_t;

	typedef logic [2:0][63:0] felem_t;

	function automatic logic [63:0] fp_canon(input logic [63:0] a);
		return (a >= FIELD_P) ? a - FIELD_P : a;
	endfunction

	function automatic logic [63:0] fp_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, FIELD_P}) begin
			s = s - {1'b0, FIELD_P};
		end
		return s[63:0];
	endfunction

	function automatic logic [63:0] fp_sub(input logic [63:0] a, input logic [63:0] b);
		return (a >= b) ? a - b : a - b + FIELD_P;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/cubic_ext_field_alu_top.sv -----
// ----------------------------------------------------------------------------
// cubic_ext_field_alu_top
// Add, subtract, multiply, negate and power over the cubic extension of the
// Goldilocks field, built around one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
// channel  | direction | tdata                                  | tuser
// s_       | in        | lhs_c0..c2, rhs_c0..c2, exponent       | command
// m_       | out       | res_c0..c2                             | -
//
// Add, subtract, negate and unused codes go from accept straight to the finish
// state. A base product runs 4 partial products, 3 reduction steps and 1 add; a
// multiply is 9 products. Power squares once per exponent bit up to the top set
// bit and multiplies once per set bit. Ready again as the result enters the output
// register, which holds while m_tready is low. Reset clears state and valid.
`default_nettype none
module cubic_ext_field_alu_top import cefa_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output      logic         s_tready,
	// lhs_c0, lhs_c1, lhs_c2, rhs_c0, rhs_c1, rhs_c2, exponent
	input  wire logic [447:0] s_tdata,
	// command
	input  wire logic [2:0]   s_tuser,
	output      logic         m_tvalid,
	input  wire logic         m_tready,
	// res_c0, res_c1, res_c2
	output      logic [191:0] m_tdata
);

	st_t          state_q, state_d;
	cmd_t         cmd_q;
	felem_t       acc_q, base_q, sum_q, sum_new, sum_init, lc, rc;
	logic [63:0]  exp_q, val_q, opa, opb, pp, t1;
	logic [127:0] prod_q, pp_ext;
	logic [1:0]   i_q, j_q, k_q;
	logic [2:0]   deg;
	logic         sq_q, mv_q, last_prod, out_load, accept;
	logic [191:0] out_q;
	cmd_t         in_cmd;

	assign in_cmd   = cmd_t'(s_tuser);
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = mv_q;
	assign m_tdata  = out_q;
	assign out_load = (state_q == ST_FIN) && (!mv_q || m_tready);

	always_comb begin
		for (int n = 0; n < 3; n++) begin
			lc[n] = fp_canon(s_tdata[64*n +: 64]);
			rc[n] = fp_canon(s_tdata[192 + 64*n +: 64]);
		end
	end

	always_comb begin
		sum_init = '0;
		for (int n = 0; n < 3; n++) begin
			case (in_cmd)
				CMD_ADD: sum_init[n] = fp_add(lc[n], rc[n]);
				CMD_SUB: sum_init[n] = fp_sub(lc[n], rc[n]);
				CMD_NEG: sum_init[n] = fp_sub(64'd0, lc[n]);
				default: sum_init[n] = 64'd0;
			endcase
		end
	end

	assign opa = sq_q ? base_q[i_q] : acc_q[i_q];
	assign opb = base_q[j_q];
	assign pp  = {32'd0, (k_q[1] ? opa[63:32] : opa[31:0])}
	           * {32'd0, (k_q[0] ? opb[63:32] : opb[31:0])};

	always_comb begin
		case (k_q)
			2'd0:    pp_ext = {64'd0, pp};
			2'd3:    pp_ext = {pp, 64'd0};
			default: pp_ext = {32'd0, pp, 32'd0};
		endcase
	end

	assign t1        = {prod_q[95:64], 32'd0} - {32'd0, prod_q[95:64]};
	assign deg       = {1'b0, i_q} + {1'b0, j_q};
	assign last_prod = (i_q == 2'd2) && (j_q == 2'd2);

	always_comb begin
		sum_new = sum_q;
		case (deg)
			3'd0: sum_new[0] = fp_add(sum_q[0], val_q);
			3'd1: sum_new[1] = fp_add(sum_q[1], val_q);
			3'd2: sum_new[2] = fp_add(sum_q[2], val_q);
			3'd3: begin
				sum_new[0] = fp_sub(sum_q[0], val_q);
				sum_new[1] = fp_add(sum_q[1], val_q);
			end
			3'd4: begin
				sum_new[1] = fp_sub(sum_q[1], val_q);
				sum_new[2] = fp_add(sum_q[2], val_q);
			end
			default: sum_new = sum_q;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_cmd)
						CMD_MUL: state_d = ST_MUL;
						CMD_POW: state_d = ST_PSTEP;
						default: state_d = ST_FIN;
					endcase
				end
			end
			ST_MUL:  if (k_q == 2'd3) state_d = ST_RED1;
			ST_RED1: state_d = ST_RED2;
			ST_RED2: state_d = ST_RED3;
			ST_RED3: state_d = ST_ACC;
			ST_ACC: begin
				if (!last_prod) begin
					state_d = ST_MUL;
				end else if (cmd_q == CMD_POW) begin
					state_d = sq_q ? ST_PSTEP : ST_MUL;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_PSTEP: state_d = (exp_q == 64'd0) ? ST_FIN : ST_MUL;
			ST_FIN:   if (out_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				mv_q <= 1'b1;
			end else if (m_tready) begin
				mv_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_q  <= in_cmd;
					exp_q  <= s_tdata[447:384];
					sq_q   <= 1'b0;
					i_q    <= 2'd0;
					j_q    <= 2'd0;
					k_q    <= 2'd0;
					prod_q <= '0;
					sum_q  <= sum_init;
					acc_q  <= (in_cmd == CMD_POW) ? {64'd0, 64'd0, 64'd1} : lc;
					base_q <= (in_cmd == CMD_POW) ? lc : rc;
				end
			end
			ST_MUL: begin
				prod_q <= prod_q + pp_ext;
				k_q    <= k_q + 2'd1;
			end
			ST_RED1: val_q <= fp_canon(prod_q[63:0]);
			ST_RED2: val_q <= fp_sub(val_q, {32'd0, prod_q[127:96]});
			ST_RED3: val_q <= fp_add(val_q, t1);
			ST_ACC: begin
				prod_q <= '0;
				k_q    <= 2'd0;
				if (last_prod && (cmd_q == CMD_POW) && !sq_q) begin
					acc_q <= sum_new;
					sq_q  <= 1'b1;
					sum_q <= '0;
					i_q   <= 2'd0;
					j_q   <= 2'd0;
				end else begin
					sum_q <= sum_new;
					if (j_q == 2'd2) begin
						j_q <= 2'd0;
						i_q <= i_q + 2'd1;
					end else begin
						j_q <= j_q + 2'd1;
					end
					if (last_prod && (cmd_q == CMD_POW)) begin
						base_q <= sum_new;
						exp_q  <= exp_q >> 1;
					end
				end
			end
			ST_PSTEP: begin
				i_q    <= 2'd0;
				j_q    <= 2'd0;
				k_q    <= 2'd0;
				prod_q <= '0;
				if (exp_q == 64'd0) begin
					sum_q <= acc_q;
				end else begin
					sum_q <= '0;
					sq_q  <= !exp_q[0];
				end
			end
			ST_FIN: if (out_load) out_q <= sum_q;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ----- hw/rtl/cefa_chk.sv -----
// ----------------------------------------------------------------------------
// cefa_chk
// Port-level checks on the extension field ALU, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cubic_ext_field_alu_top_macros.svh"
module cefa_chk import cefa_pkg::*; (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [191:0] m_tdata
);

	logic res_canon;

	assign res_canon = (m_tdata[63:0] < FIELD_P) && (m_tdata[127:64] < FIELD_P)
	                && (m_tdata[191:128] < FIELD_P);

	`CEFA_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "held item changed")
	`CEFA_ASSERT_NOW(a_canon, m_tvalid, res_canon, "result not reduced")
	`CEFA_ASSERT_NXT(a_busy, s_tvalid && s_tready, !s_tready, "ready straight after accept")

endmodule

bind cubic_ext_field_alu_top cefa_chk u_cefa_chk (.*);
`default_nettype wire

// ----- tb/sv/tb_cubic_ext_field_alu_top.sv -----
// ----------------------------------------------------------------------------
// tb_cubic_ext_field_alu_top
// Self-checking bench for the cubic extension field ALU: directed edge
// operands, every command, a long output hold-off, then random items, first
// with idle bursts on both sides and then without. Results are predicted with
// wide modular arithmetic and compared in order of acceptance.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_cubic_ext_field_alu_top import cefa_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0]  CMD_SPARE_LO = 3'd5;
	localparam logic [2:0]  CMD_SPARE_HI = 3'd7;
	localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam int          STALL_LIMIT  = 50000;
	localparam int          HOLD_CYCLES  = 400;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [447:0] s_tdata;
	logic [2:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [191:0] m_tdata;

	felem_t pending_res[$];
	int     err_count;
	int     stall_cycles;
	bit     send_idle_en;
	bit     recv_idle_en;
	bit     hold_req;

	cubic_ext_field_alu_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic logic [63:0] gf_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		s = s % {1'b0, FIELD_P};
		return s[63:0];
	endfunction

	function automatic logic [63:0] gf_sub(input logic [63:0] a, input logic [63:0] b);
		return (a >= b) ? a - b : (FIELD_P - b) + a;
	endfunction

	function automatic logic [63:0] gf_mul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] t;
		t = {64'd0, a} * {64'd0, b};
		t = t % {64'd0, FIELD_P};
		return t[63:0];
	endfunction

	// reduce the degree-4 product with x^3 = x - 1, x^4 = x^2 - x
	function automatic felem_t ext_product(input felem_t l, input felem_t r);
		logic [63:0] d [0:4];
		felem_t      o;
		for (int k = 0; k < 5; k++) begin
			d[k] = '0;
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				d[i+j] = gf_add(d[i+j], gf_mul(l[i], r[j]));
			end
		end
		o[0] = gf_sub(d[0], d[3]);
		o[1] = gf_sub(gf_add(d[1], d[3]), d[4]);
		o[2] = gf_add(d[2], d[4]);
		return o;
	endfunction

	function automatic felem_t predict_result(input logic [2:0] cmd, input felem_t lhs_raw,
			input felem_t rhs_raw, input logic [63:0] expo);
		felem_t l, r, o, acc, base;
		for (int i = 0; i < 3; i++) begin
			l[i] = lhs_raw[i] % FIELD_P;
			r[i] = rhs_raw[i] % FIELD_P;
			o[i] = '0;
		end
		case (cmd)
			CMD_ADD: for (int i = 0; i < 3; i++) o[i] = gf_add(l[i], r[i]);
			CMD_SUB: for (int i = 0; i < 3; i++) o[i] = gf_sub(l[i], r[i]);
			CMD_MUL: o = ext_product(l, r);
			CMD_NEG: for (int i = 0; i < 3; i++) o[i] = gf_sub(64'd0, l[i]);
			CMD_POW: begin
				acc  = {64'd0, 64'd0, 64'd1};
				base = l;
				for (int k = 0; k < 64; k++) begin
					if (expo[k]) begin
						acc = ext_product(acc, base);
					end
					base = ext_product(base, base);
				end
				o = acc;
			end
			default: o = '0;
		endcase
		return o;
	endfunction

	function automatic logic [63:0] rand_coef();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = FIELD_P - 64'd1;
			2: v = FIELD_P + {32'd0, $urandom} % (ALL_ONES - FIELD_P + 64'd1);
			3: v = ALL_ONES;
			4: v = {32'd0, $urandom_range(0, 15)};
			default: ;
		endcase
		return v;
	endfunction

	function automatic felem_t rand_elem();
		felem_t e;
		for (int i = 0; i < 3; i++) begin
			e[i] = rand_coef();
		end
		return e;
	endfunction

	task automatic report_mismatch(input string fld, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t mismatch %s: got %h want %h", $realtime, fld, got, want);
		err_count++;
	endtask

	task automatic send_item(input logic [2:0] cmd, input felem_t lhs, input felem_t rhs,
			input logic [63:0] expo);
		if (send_idle_en && $urandom_range(0, 5) == 0) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat ($urandom_range(0, 17)) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser  = cmd;
		s_tdata  = {expo, rhs[2], rhs[1], rhs[0], lhs[2], lhs[1], lhs[0]};
		do begin
			@(posedge clk);
		end while (!s_tready);
		pending_res.insert(pending_res.size(), predict_result(cmd, lhs, rhs, expo));
	endtask

	task automatic send_random(input bit allow_long);
		logic [2:0]  cmd;
		logic [63:0] expo;
		int unsigned pick;
		pick = $urandom_range(0, 11);
		expo = {$urandom, $urandom};
		if (pick > 32'(CMD_SPARE_HI)) begin
			cmd = $urandom_range(0, 1) ? CMD_MUL : CMD_POW;
		end else begin
			cmd = 3'(pick);
		end
		if (cmd == CMD_POW && !(allow_long && $urandom_range(0, 99) == 0)) begin
			expo = expo >> $urandom_range(56, 63);
		end
		send_item(cmd, rand_elem(), rand_elem(), expo);
	endtask

	task automatic test_edges();
		felem_t zero, top, over, one;
		zero = '0;
		top  = {FIELD_P - 64'd1, FIELD_P - 64'd1, FIELD_P - 64'd1};
		over = {ALL_ONES, FIELD_P, FIELD_P + 64'd1};
		one  = {64'd0, 64'd0, 64'd1};
		send_item(CMD_ADD, top, top, '0);
		send_item(CMD_ADD, over, over, ALL_ONES);
		send_item(CMD_SUB, zero, top, '0);
		send_item(CMD_SUB, over, zero, '0);
		send_item(CMD_MUL, top, top, '0);
		send_item(CMD_MUL, over, top, '0);
		send_item(CMD_NEG, zero, top, '0);
		send_item(CMD_NEG, over, zero, '0);
		send_item(CMD_POW, zero, top, '0);
		send_item(CMD_POW, top, zero, '0);
		send_item(CMD_POW, over, zero, 64'd1);
		send_item(CMD_POW, one, zero, 64'd5);
		send_item(CMD_POW, top, zero, ALL_ONES);
	endtask

	task automatic test_each_command();
		for (logic [3:0] c = 0; c <= 4'(CMD_SPARE_HI); c++) begin
			send_item(c[2:0], rand_elem(), rand_elem(), {56'd0, 8'($urandom_range(0, 255))});
		end
		send_item(CMD_SPARE_LO, {ALL_ONES, ALL_ONES, ALL_ONES}, rand_elem(), ALL_ONES);
	endtask

	task automatic test_output_hold();
		hold_req = 1'b1;
		for (int n = 0; n < 5; n++) begin
			send_item(CMD_ADD, rand_elem(), rand_elem(), '0);
		end
		wait (!hold_req);
	endtask

	task automatic test_random(input int count, input bit allow_long);
		for (int n = 0; n < count; n++) begin
			send_random(allow_long);
		end
	endtask

	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				m_tready = 1'b1;
			end else if (recv_idle_en && $urandom_range(0, 7) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(0, 17)) @(negedge clk);
				m_tready = 1'b1;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		felem_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_res.size() == 0) begin
				report_mismatch("unexpected res_c0", m_tdata[63:0], '0);
			end else begin
				want = pending_res.pop_front();
				for (int i = 0; i < 3; i++) begin
					if (m_tdata[64*i +: 64] !== want[i]) begin
						report_mismatch($sformatf("res_c%0d", i), m_tdata[64*i +: 64], want[i]);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_cubic_ext_field_alu_top: done, errors");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int waited;
		err_count    = 0;
		stall_cycles = 0;
		hold_req     = 1'b0;
		send_idle_en = 1'b1;
		recv_idle_en = 1'b1;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		m_tready     = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		test_edges();
		test_each_command();
		test_output_hold();
		test_random(820, 1'b1);
		send_idle_en = 1'b0;
		recv_idle_en = 1'b0;
		test_random(150, 1'b0);
		@(negedge clk);
		s_tvalid = 1'b0;
		waited = 0;
		while (pending_res.size() != 0 && waited < STALL_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (err_count == 0 && pending_res.size() == 0) begin
			$display("tb_cubic_ext_field_alu_top: done, clean");
		end else begin
			$display("tb_cubic_ext_field_alu_top: done, errors");
		end
		$finish;
	end

endmodule
`default_nettype wire
